@@ rtl/bpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpcm_pkg
// Shared types, constants and term tables for the bivariate polynomial
// current model.
// ----------------------------------------------------------------------------
package bpcm_pkg;

    // fixed term count and default number format
    localparam int NUM_TERMS          = 23;
    localparam int FRAC_BITS_DEFAULT  = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // field widths
    localparam int VAL_W     = 32;
    localparam int STD_W     = 31;
    localparam int IDX_W     = 5;
    localparam int POW_W     = 3;
    localparam int CFG_IDX_W = 2;

    // input tdata layout, lowest bit first
    localparam int IN_TDATA_W = 104;
    localparam int COEF_IDX_LSB = 0;
    localparam int COEF_VAL_LSB = COEF_IDX_LSB + IDX_W;
    localparam int TORQUE_LSB   = COEF_VAL_LSB + VAL_W;
    localparam int SPEED_LSB    = TORQUE_LSB + VAL_W;

    // request kinds carried on tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_MEAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_INV_STD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MEAN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_INV_STD  = 2'd3;

    // highest power held per variable
    localparam logic [POW_W-1:0] POW_MAX = 3'd6;

    typedef logic [IDX_W-1:0] term_idx_t;
    typedef logic [POW_W-1:0] pow_t;

    // exponent of x for each term
    function automatic pow_t pow_x(input term_idx_t idx);
        pow_t p;
        case (idx)
            5'd1:    p = 3'd1;
            5'd3:    p = 3'd2;
            5'd5:    p = 3'd1;
            5'd6:    p = 3'd3;
            5'd8:    p = 3'd2;
            5'd9:    p = 3'd1;
            5'd10:   p = 3'd4;
            5'd12:   p = 3'd3;
            5'd13:   p = 3'd2;
            5'd14:   p = 3'd1;
            5'd15:   p = 3'd5;
            5'd17:   p = 3'd4;
            5'd18:   p = 3'd3;
            5'd19:   p = 3'd2;
            5'd20:   p = 3'd1;
            5'd21:   p = 3'd6;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    // exponent of y for each term
    function automatic pow_t pow_y(input term_idx_t idx);
        pow_t p;
        case (idx)
            5'd2:    p = 3'd1;
            5'd4:    p = 3'd2;
            5'd5:    p = 3'd1;
            5'd7:    p = 3'd3;
            5'd8:    p = 3'd1;
            5'd9:    p = 3'd2;
            5'd11:   p = 3'd4;
            5'd12:   p = 3'd1;
            5'd13:   p = 3'd2;
            5'd14:   p = 3'd3;
            5'd16:   p = 3'd5;
            5'd17:   p = 3'd1;
            5'd18:   p = 3'd2;
            5'd19:   p = 3'd3;
            5'd20:   p = 3'd4;
            5'd22:   p = 3'd6;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/bpcm_mulq.sv @@
// ----------------------------------------------------------------------------
// bpcm_mulq
// Shared fixed-point multiplier: round(a*b / 2^FRAC_BITS), ties away from
// zero, saturated to the signed DATA_WIDTH range. It computes one product at a time and takes start only while idle.
// ----------------------------------------------------------------------------
module bpcm_mulq
    import bpcm_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    localparam int OPW = (DATA_WIDTH > 33) ? DATA_WIDTH : 33
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [OPW-1:0]        a,
    input  logic signed [OPW-1:0]        b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result
);

    localparam int HW  = (OPW + 1) / 2;
    localparam int HIW = OPW - HW;
    localparam int PW  = 2 * OPW;
    localparam int MFW = PW + 1 - FRAC_BITS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_RND  = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [OPW-1:0]              ma_reg, mb_reg;
    logic                        neg_reg;
    logic [PW-1:0]               prod_reg;
    logic signed [DATA_WIDTH-1:0] result_reg, result_next;
    logic                        done_reg;

    logic [OPW+HW-1:0]     lo_prod;
    logic [OPW+HIW-1:0]    hi_prod;
    logic [PW:0]           rnd_sum;
    logic [MFW-1:0]        mag_full;
    logic [DATA_WIDTH-1:0] lim;
    logic [DATA_WIDTH-1:0] mag;

    // partial products on the low and high halves of b
    assign lo_prod = ma_reg * mb_reg[HW-1:0];
    assign hi_prod = ma_reg * mb_reg[OPW-1:HW];

    // round to nearest and clamp the magnitude
    always_comb
    begin
        rnd_sum  = {1'b0, prod_reg} + ((PW+1)'(1) << (FRAC_BITS - 1));
        mag_full = MFW'(rnd_sum >> FRAC_BITS);
        lim      = (DATA_WIDTH'(1) << (DATA_WIDTH - 1)) - DATA_WIDTH'(!neg_reg);
        if (mag_full > MFW'(lim))
        begin
            mag = lim;
        end
        else
        begin
            mag = mag_full[DATA_WIDTH-1:0];
        end
        result_next = neg_reg ? $signed(-mag) : $signed(mag);
    end

    // phase sequencing
    always_comb
    begin
        case (phase_reg)
            PH_IDLE: phase_next = start ? PH_LO : PH_IDLE;
            PH_LO:   phase_next = PH_HI;
            PH_HI:   phase_next = PH_RND;
            PH_RND:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_RND);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    ma_reg  <= a[OPW-1] ? OPW'(-a) : OPW'(a);
                    mb_reg  <= b[OPW-1] ? OPW'(-b) : OPW'(b);
                    neg_reg <= a[OPW-1] ^ b[OPW-1];
                end
            end
            PH_LO:   prod_reg <= PW'(lo_prod);
            PH_HI:   prod_reg <= prod_reg + (PW'(hi_prod) << HW);
            PH_RND:  result_reg <= result_next;
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/bivariate_poly_current_model.sv @@
// Evaluate: 58 products run one after another through the single shared
// multiplier; a new evaluate is taken only once the last one is done.
// Throughput: loads one per cycle while the input is ready.
// Input is not ready during an evaluation, and at its end it stays low while
// an earlier result still waits for m_axis_tready.
// Reset (rst_n, async, active low) zeroes coefficients and means, deviations 1.0
// ----------------------------------------------------------------------------
// bivariate_poly_current_model
// Predicts motor DC current from torque and speed with a 23-term bivariate
// polynomial, summed in fixed point with a loadable coefficient table.
// ----------------------------------------------------------------------------
module bivariate_poly_current_model
    import bpcm_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // coef_index[4:0], coef_value[36:5], torque[68:37], speed[100:69], zero pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // current[31:0]
    output logic [VAL_W-1:0]      m_axis_tdata,
    // overflow
    output logic                  m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VAL_W-1:0]      cfg_data
);

    localparam int OPW  = (DATA_WIDTH > 33) ? DATA_WIDTH : 33;
    localparam int ACCW = (DATA_WIDTH + 5 > 33) ? DATA_WIDTH + 5 : 33;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [2:0] PH_XN   = 3'd0;
    localparam logic [2:0] PH_YN   = 3'd1;
    localparam logic [2:0] PH_XPOW = 3'd2;
    localparam logic [2:0] PH_YPOW = 3'd3;
    localparam logic [2:0] PH_MONO = 3'd4;
    localparam logic [2:0] PH_TERM = 3'd5;

    localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [IDX_W-1:0] LAST_TERM = IDX_W'(NUM_TERMS - 1);

    // configuration registers
    logic signed [VAL_W-1:0] torque_mean_reg, speed_mean_reg;
    logic [STD_W-1:0]        torque_inv_std_reg, speed_inv_std_reg;

    // working state
    logic [1:0]       state_reg, state_next;
    logic [2:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic signed [VAL_W-1:0]      coef_reg [NUM_TERMS];
    logic signed [VAL_W:0]        diff_t_reg, diff_s_reg;
    logic signed [DATA_WIDTH-1:0] xp_reg [7];
    logic signed [DATA_WIDTH-1:0] yp_reg [7];
    logic signed [DATA_WIDTH-1:0] mono_reg;
    logic signed [ACCW-1:0]       acc_reg;

    // output register
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_data_reg;
    logic             out_ovf_reg;

    logic                         in_xfer;
    logic                         mul_start;
    logic signed [OPW-1:0]        mul_a, mul_b;
    logic                         mul_done;
    logic signed [DATA_WIDTH-1:0] mul_result;
    logic [POW_W-1:0]             pow_idx;
    logic [VAL_W-1:0]             sat_data;
    logic                         sat_ovf;
    logic signed [ACCW-1:0]       acc_max, acc_min;

    logic [IDX_W-1:0]        in_coef_idx;
    logic signed [VAL_W-1:0] in_coef_val, in_torque, in_speed;

    assign in_coef_idx = s_axis_tdata[COEF_IDX_LSB +: IDX_W];
    assign in_coef_val = s_axis_tdata[COEF_VAL_LSB +: VAL_W];
    assign in_torque   = s_axis_tdata[TORQUE_LSB +: VAL_W];
    assign in_speed    = s_axis_tdata[SPEED_LSB +: VAL_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign mul_start     = (state_reg == ST_ISSUE);
    assign pow_idx       = cnt_reg[POW_W-1:0];

    // operand selection for the shared multiplier
    always_comb
    begin
        case (phase_reg)
            PH_XN:
            begin
                mul_a = OPW'(diff_t_reg);
                mul_b = OPW'($signed({1'b0, torque_inv_std_reg}));
            end
            PH_YN:
            begin
                mul_a = OPW'(diff_s_reg);
                mul_b = OPW'($signed({1'b0, speed_inv_std_reg}));
            end
            PH_XPOW:
            begin
                mul_a = OPW'(xp_reg[pow_idx - POW_W'(1)]);
                mul_b = OPW'(xp_reg[1]);
            end
            PH_YPOW:
            begin
                mul_a = OPW'(yp_reg[pow_idx - POW_W'(1)]);
                mul_b = OPW'(yp_reg[1]);
            end
            PH_MONO:
            begin
                mul_a = OPW'(xp_reg[pow_x(cnt_reg)]);
                mul_b = OPW'(yp_reg[pow_y(cnt_reg)]);
            end
            PH_TERM:
            begin
                mul_a = OPW'(coef_reg[cnt_reg]);
                mul_b = OPW'(mono_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bpcm_mulq #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mulq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_result)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_axis_tuser == REQ_EVAL))
                begin
                    state_next = ST_ISSUE;
                    phase_next = PH_XN;
                    cnt_next   = '0;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_ISSUE;
                    case (phase_reg)
                        PH_XN:
                        begin
                            phase_next = PH_YN;
                        end
                        PH_YN:
                        begin
                            phase_next = PH_XPOW;
                            cnt_next   = IDX_W'(2);
                        end
                        PH_XPOW:
                        begin
                            if (pow_idx == POW_MAX)
                            begin
                                phase_next = PH_YPOW;
                                cnt_next   = IDX_W'(2);
                            end
                            else
                            begin
                                cnt_next = cnt_reg + IDX_W'(1);
                            end
                        end
                        PH_YPOW:
                        begin
                            if (pow_idx == POW_MAX)
                            begin
                                phase_next = PH_MONO;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + IDX_W'(1);
                            end
                        end
                        PH_MONO:
                        begin
                            phase_next = PH_TERM;
                        end
                        PH_TERM:
                        begin
                            if (cnt_reg == LAST_TERM)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                phase_next = PH_MONO;
                                cnt_next   = cnt_reg + IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // final saturation of the sum to 32 bits
    always_comb
    begin
        acc_max = $signed({{(ACCW-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
        acc_min = $signed({{(ACCW-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});
        if (acc_reg > acc_max)
        begin
            sat_data = acc_max[VAL_W-1:0];
            sat_ovf  = 1'b1;
        end
        else if (acc_reg < acc_min)
        begin
            sat_data = acc_min[VAL_W-1:0];
            sat_ovf  = 1'b1;
        end
        else
        begin
            sat_data = acc_reg[VAL_W-1:0];
            sat_ovf  = 1'b0;
        end
    end

    // control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_XN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers and coefficient table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_mean_reg    <= '0;
            torque_inv_std_reg <= STD_W'(65536);
            speed_mean_reg     <= '0;
            speed_inv_std_reg  <= STD_W'(65536);
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TORQUE_MEAN:    torque_mean_reg    <= cfg_data;
                    CFG_TORQUE_INV_STD: torque_inv_std_reg <= cfg_data[STD_W-1:0];
                    CFG_SPEED_MEAN:     speed_mean_reg     <= cfg_data;
                    CFG_SPEED_INV_STD:  speed_inv_std_reg  <= cfg_data[STD_W-1:0];
                    default: ;
                endcase
            end
            if (in_xfer && (s_axis_tuser == REQ_LOAD) && (in_coef_idx <= LAST_TERM))
            begin
                coef_reg[in_coef_idx] <= in_coef_val;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer && (s_axis_tuser == REQ_EVAL))
        begin
            diff_t_reg <= $signed({in_torque[VAL_W-1], in_torque})
                        - $signed({torque_mean_reg[VAL_W-1], torque_mean_reg});
            diff_s_reg <= $signed({in_speed[VAL_W-1], in_speed})
                        - $signed({speed_mean_reg[VAL_W-1], speed_mean_reg});
            xp_reg[0]  <= ONE;
            yp_reg[0]  <= ONE;
            acc_reg    <= '0;
        end
        if ((state_reg == ST_WAIT) && mul_done)
        begin
            case (phase_reg)
                PH_XN:   xp_reg[1] <= mul_result;
                PH_YN:   yp_reg[1] <= mul_result;
                PH_XPOW: xp_reg[pow_idx] <= mul_result;
                PH_YPOW: yp_reg[pow_idx] <= mul_result;
                PH_MONO: mono_reg <= mul_result;
                PH_TERM: acc_reg <= acc_reg + ACCW'(mul_result);
                default: ;
            endcase
        end
        if ((state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= sat_data;
            out_ovf_reg  <= sat_ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

@@ rtl/bpcm_checker.sv @@
// ----------------------------------------------------------------------------
// bpcm_checker
// Port-level checks for the bivariate polynomial current model, bound to
// the top level.
// ----------------------------------------------------------------------------
module bpcm_checker
    import bpcm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [VAL_W-1:0]      m_axis_tdata,
    input logic                  m_axis_tuser
);

    // stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // overflow only with a clamped value
    a_ovf_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000))
        else $error("overflow flag without saturated current");

    // an evaluate transfer makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_EVAL) |=> !s_axis_tready)
        else $error("input ready right after an evaluate transfer");

    // a load transfer leaves the input ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD) |=> s_axis_tready)
        else $error("input not ready after a load transfer");

    // a new result only comes at the end of an evaluation
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

bind bivariate_poly_current_model bpcm_checker u_bpcm_checker (.*);

@@ verif/bpcm_current_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpcm_current_checker
// Watches the config port and both stream channels of the current model.
// Keeps its own coefficient table and normalization registers, predicts the
// result of every evaluate transfer and compares it with the output stream.
// ----------------------------------------------------------------------------
module bpcm_current_checker
    import bpcm_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // coef_index[4:0], coef_value[36:5], torque[68:37], speed[100:69], zero pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // current[31:0]
    input  logic [VAL_W-1:0]      m_axis_tdata,
    // overflow
    input  logic                  m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VAL_W-1:0]      cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [VAL_W-1:0] current;
        logic             overflow;
    } current_result_t;

    // shadow copy of the block state
    logic signed [VAL_W-1:0] coef_table [NUM_TERMS];
    logic signed [VAL_W-1:0] torque_mean;
    logic signed [VAL_W-1:0] speed_mean;
    logic [STD_W-1:0]        torque_inv_std;
    logic [STD_W-1:0]        speed_inv_std;

    current_result_t current_expected_q [$];

    // exponents {x, y} of each term, in table order
    function automatic logic [5:0] term_exponents(input int k);
        case (k)
            0:       return {3'd0, 3'd0};
            1:       return {3'd1, 3'd0};
            2:       return {3'd0, 3'd1};
            3:       return {3'd2, 3'd0};
            4:       return {3'd0, 3'd2};
            5:       return {3'd1, 3'd1};
            6:       return {3'd3, 3'd0};
            7:       return {3'd0, 3'd3};
            8:       return {3'd2, 3'd1};
            9:       return {3'd1, 3'd2};
            10:      return {3'd4, 3'd0};
            11:      return {3'd0, 3'd4};
            12:      return {3'd3, 3'd1};
            13:      return {3'd2, 3'd2};
            14:      return {3'd1, 3'd3};
            15:      return {3'd5, 3'd0};
            16:      return {3'd0, 3'd5};
            17:      return {3'd4, 3'd1};
            18:      return {3'd3, 3'd2};
            19:      return {3'd2, 3'd3};
            20:      return {3'd1, 3'd4};
            21:      return {3'd6, 3'd0};
            22:      return {3'd0, 3'd6};
            default: return {3'd0, 3'd0};
        endcase
    endfunction

    // fixed-point product, rounded half away from zero, clamped to DATA_WIDTH
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] mag;
        logic [127:0] lim;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = {64'd0, (a < 0) ? -a : a};
        ub  = {64'd0, (b < 0) ? -b : b};
        mag = (ua * ub + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = (128'd1 << (DATA_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
        if (mag > lim)
            mag = lim;
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    // polynomial value for one torque and speed pair
    function automatic current_result_t predict_current(
        input logic signed [VAL_W-1:0] torque,
        input logic signed [VAL_W-1:0] speed
    );
        longint          xp [7];
        longint          yp [7];
        longint          acc;
        longint          mono;
        logic [5:0]      e;
        current_result_t r;
        xp[0] = longint'(1) << FRAC_BITS;
        yp[0] = xp[0];
        xp[1] = fx_mul(longint'(torque) - longint'(torque_mean),
                       longint'({1'b0, torque_inv_std}));
        yp[1] = fx_mul(longint'(speed) - longint'(speed_mean),
                       longint'({1'b0, speed_inv_std}));
        for (int p = 2; p < 7; p++)
        begin
            xp[p] = fx_mul(xp[p-1], xp[1]);
            yp[p] = fx_mul(yp[p-1], yp[1]);
        end
        acc = 0;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            e    = term_exponents(k);
            mono = fx_mul(xp[e[5:3]], yp[e[2:0]]);
            acc  = acc + fx_mul(longint'(coef_table[k]), mono);
        end
        // only the final sum reports saturation
        if (acc > 64'sd2147483647)
        begin
            r.current  = 32'h7FFF_FFFF;
            r.overflow = 1'b1;
        end
        else if (acc < -64'sd2147483648)
        begin
            r.current  = 32'h8000_0000;
            r.overflow = 1'b1;
        end
        else
        begin
            r.current  = acc[31:0];
            r.overflow = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        current_result_t  want;
        logic [IDX_W-1:0] idx;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TERMS; k++)
                coef_table[k] = '0;
            torque_mean    = '0;
            speed_mean     = '0;
            torque_inv_std = STD_W'(32'h0001_0000);
            speed_inv_std  = STD_W'(32'h0001_0000);
            current_expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // register writes, top bit of the deviations dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TORQUE_MEAN:    torque_mean    = cfg_data;
                    CFG_TORQUE_INV_STD: torque_inv_std = cfg_data[STD_W-1:0];
                    CFG_SPEED_MEAN:     speed_mean     = cfg_data;
                    CFG_SPEED_INV_STD:  speed_inv_std  = cfg_data[STD_W-1:0];
                    default: ;
                endcase
            end

            // output transfer against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (current_expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, actual current %h overflow %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = current_expected_q.pop_front();
                    if (m_axis_tdata !== want.current)
                    begin
                        errors++;
                        $display("%0t: current expected %h actual %h",
                                 $time, want.current, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.overflow)
                    begin
                        errors++;
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, m_axis_tuser);
                    end
                end
            end

            // input transfer: table write or new prediction
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == REQ_LOAD)
                begin
                    idx = s_axis_tdata[COEF_IDX_LSB +: IDX_W];
                    if (idx < NUM_TERMS)
                        coef_table[idx] = s_axis_tdata[COEF_VAL_LSB +: VAL_W];
                end
                else
                begin
                    current_expected_q.push_back(
                        predict_current(s_axis_tdata[TORQUE_LSB +: VAL_W],
                                        s_axis_tdata[SPEED_LSB +: VAL_W]));
                end
            end
            pending = current_expected_q.size();
        end
    end

endmodule

@@ verif/tb_bivariate_poly_current_model.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bivariate_poly_current_model
// Drives load and evaluate transfers into the current model under several
// normalization settings and idle patterns; a checker beside the block
// predicts each result and counts mismatches, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bivariate_poly_current_model;
    import bpcm_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int EVAL_LATENCY    = 300;
    localparam int LOAD_SETTLE     = 10;
    localparam logic [VAL_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [VAL_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [VAL_W-1:0] Q_M_ONE = 32'hFFFF_0000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [VAL_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [VAL_W-1:0]      cfg_data      = '0;

    int errors;
    int pending;
    int send_idle_pct = 17;
    int recv_idle_pct = 51;
    int stall_cycles  = 0;

    always #5 clk = ~clk;

    bivariate_poly_current_model dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bpcm_current_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    // receiver back-pressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_bivariate_poly_current_model NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_request(
        input logic [IDX_W-1:0] idx,
        input logic [VAL_W-1:0] coef,
        input logic [VAL_W-1:0] torque,
        input logic [VAL_W-1:0] speed
    );
        logic [IN_TDATA_W-1:0] v;
        v = '0;
        v[COEF_IDX_LSB +: IDX_W] = idx;
        v[COEF_VAL_LSB +: VAL_W] = coef;
        v[TORQUE_LSB +: VAL_W]   = torque;
        v[SPEED_LSB +: VAL_W]    = speed;
        return v;
    endfunction

    // value around a center, with some full-range and extreme picks
    function automatic logic [VAL_W-1:0] near_value(input logic [VAL_W-1:0] center,
                                                     input int span);
        int off;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return Q_MIN;
                    1:       return Q_MAX;
                    2:       return '0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                off = int'($urandom_range(0, 2 * span)) - span;
                return center + off;
            end
        endcase
    endfunction

    // one input transfer, called and returning at a falling edge
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] coef,
                             input logic [VAL_W-1:0] torque,
                             input logic [VAL_W-1:0] speed);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= pack_request(idx, coef, torque, speed);
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LOAD_SETTLE) @(negedge clk);
    endtask

    // write all four normalization registers
    task automatic write_config(input logic [VAL_W-1:0] tm, input logic [VAL_W-1:0] ti,
                                input logic [VAL_W-1:0] sm, input logic [VAL_W-1:0] si);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TORQUE_MEAN;
        cfg_data  <= tm;
        @(negedge clk);
        cfg_index <= CFG_TORQUE_INV_STD;
        cfg_data  <= ti;
        @(negedge clk);
        cfg_index <= CFG_SPEED_MEAN;
        cfg_data  <= sm;
        @(negedge clk);
        cfg_index <= CFG_SPEED_INV_STD;
        cfg_data  <= si;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [VAL_W-1:0] tm;
        logic [VAL_W-1:0] ti;
        logic [VAL_W-1:0] sm;
        logic [VAL_W-1:0] si;
        logic [IDX_W-1:0] idx;
        tm = '0;
        sm = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, ignored indexes, extremes, rounding ties
        send_item(REQ_EVAL, '0, '0, '0, '0);
        send_item(REQ_LOAD, 5'd0, Q_ONE, '0, '0);
        send_item(REQ_EVAL, '0, '0, '0, '0);
        send_item(REQ_LOAD, 5'd31, Q_MAX, '0, '0);
        send_item(REQ_LOAD, 5'd23, Q_MIN, '0, '0);
        send_item(REQ_EVAL, '0, '0, 32'h0002_0000, Q_M_ONE);
        send_item(REQ_LOAD, 5'd1, Q_MAX, '0, '0);
        send_item(REQ_LOAD, 5'd22, Q_MIN, '0, '0);
        send_item(REQ_EVAL, 5'd31, 32'hFFFF_FFFF, Q_MAX, Q_MIN);
        send_item(REQ_EVAL, '0, '0, Q_MIN, Q_MAX);
        send_item(REQ_LOAD, 5'd1, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, 5'd22, 32'h0000_0001, '0, '0);
        send_item(REQ_EVAL, '0, '0, '0, Q_MAX);
        send_item(REQ_LOAD, 5'd13, Q_M_ONE, '0, '0);
        send_item(REQ_EVAL, '0, '0, 32'h0001_8000, 32'h0001_8000);
        send_item(REQ_LOAD, 5'd2, 32'h0000_8000, '0, '0);
        send_item(REQ_EVAL, '0, '0, '0, 32'h0000_0001);
        send_item(REQ_EVAL, '0, '0, '0, 32'hFFFF_FFFF);

        // random phases, each with its own settings; each pair of phases shares an idle pattern
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:
                begin
                    tm = '0;
                    ti = Q_ONE;
                    sm = '0;
                    si = Q_ONE;
                end
                2:
                begin
                    tm = Q_MIN;
                    ti = Q_MAX;
                    sm = Q_MAX;
                    si = '0;
                end
                3:
                begin
                    // bit 31 of the deviations is dropped by the block
                    tm = Q_MAX;
                    ti = 32'hFFFF_FFFF;
                    sm = Q_MIN;
                    si = 32'h8000_0001;
                end
                default:
                begin
                    tm = int'($urandom_range(0, 20 << 16)) - (10 << 16);
                    ti = $urandom_range(32'h0000_2000, 32'h0002_0000);
                    sm = int'($urandom_range(0, 20 << 16)) - (10 << 16);
                    si = $urandom_range(32'h0000_2000, 32'h0002_0000);
                end
            endcase
            write_config(tm, ti, sm, si);
            @(negedge clk);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold off until the pipeline is empty
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 35)
                begin
                    if ($urandom_range(0, 9) == 0)
                        idx = IDX_W'($urandom_range(NUM_TERMS, 31));
                    else
                        idx = IDX_W'($urandom_range(0, NUM_TERMS - 1));
                    send_item(REQ_LOAD, idx, near_value('0, 2 << 16), $urandom, $urandom);
                end
                else
                begin
                    send_item(REQ_EVAL, IDX_W'($urandom_range(0, 31)), $urandom,
                              near_value(tm, 3 << 16), near_value(sm, 3 << 16));
                end
            end
        end

        drain_results();
        repeat (EVAL_LATENCY) @(negedge clk);
        if (errors == 0)
            $display("tb_bivariate_poly_current_model OK");
        else
            $display("tb_bivariate_poly_current_model NOT OK");
        $finish;
    end

endmodule
